/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL that checks itself.
// No dependencies; expects clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define BSB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every clock edge, reset included.
`define BSB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/bsb_pkg.sv */
// Package for the bounded stack bank: sizes, codes and the decision struct.
// No dependencies.
`default_nettype none

package bsb_pkg;

  localparam int NUM_STACKS = 16;
  localparam int MAX_DEPTH  = 16;
  localparam int DATA_WIDTH = 16;

  localparam int FUNC_W = 2;
  localparam int VAL_W  = 16;
  localparam int IDX_W  = 4;
  localparam int CAP_W  = 5;

  localparam int SIDX_W  = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int DIDX_W  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int FILL_W  = $clog2(MAX_DEPTH + 1);
  localparam int ADDR_W  = SIDX_W + DIDX_W;
  localparam int RAM_DEPTH = NUM_STACKS * (1 << DIDX_W);

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH   = 2'd0,
    FUNC_POP    = 2'd1,
    FUNC_POP_AT = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic              hit;
    logic              is_pop;
    logic [ADDR_W-1:0] addr;
    status_t           status;
  } bsb_dec_t;

endpackage

`default_nettype wire

/* hw/rtl/bsb_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none

module bsb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                          clk,
  input  wire logic                          we,
  input  wire logic [$clog2(DEPTH)-1:0]      waddr,
  input  wire logic [WIDTH-1:0]              wdata,
  input  wire logic                          re,
  input  wire logic [$clog2(DEPTH)-1:0]      raddr,
  output logic      [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/bsb_ctrl.sv */
// Fill-count file and stack selection for the bounded stack bank.
// Depends on bsb_pkg.
`default_nettype none

module bsb_ctrl
  import bsb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire logic [FUNC_W-1:0] func,
  input  wire logic [IDX_W-1:0]  stack_index,
  input  wire logic [FILL_W-1:0] cap_eff,
  output bsb_dec_t               dec
);

  logic [FILL_W-1:0] fill_r [NUM_STACKS];

  logic              push_found;
  logic [SIDX_W-1:0] push_sel;
  logic              pop_found;
  logic [SIDX_W-1:0] pop_sel;
  logic [SIDX_W-1:0] sel;
  logic [FILL_W-1:0] sel_fill;
  logic [FILL_W-1:0] sel_fill_nxt;

  // Lowest stack with room, highest stack with a value.
  always_comb begin
    push_found = 1'b0;
    push_sel   = '0;
    pop_found  = 1'b0;
    pop_sel    = '0;
    for (int s = NUM_STACKS - 1; s >= 0; s--) begin
      if (fill_r[s] < cap_eff) begin
        push_found = 1'b1;
        push_sel   = SIDX_W'(s);
      end
    end
    for (int s = 0; s < NUM_STACKS; s++) begin
      if (fill_r[s] != '0) begin
        pop_found = 1'b1;
        pop_sel   = SIDX_W'(s);
      end
    end
  end

  always_comb begin
    dec.hit    = 1'b0;
    dec.is_pop = 1'b0;
    dec.status = ST_OK;
    sel        = '0;
    unique case (func_t'(func))
      FUNC_PUSH: begin
        sel        = push_sel;
        dec.hit    = push_found;
        dec.status = push_found ? ST_OK : ST_FULL;
      end
      FUNC_POP: begin
        sel        = pop_sel;
        dec.is_pop = 1'b1;
        dec.hit    = pop_found;
        dec.status = pop_found ? ST_OK : ST_EMPTY;
      end
      FUNC_POP_AT: begin
        sel        = SIDX_W'(stack_index);
        dec.is_pop = 1'b1;
        dec.hit    = (32'(stack_index) < NUM_STACKS) && (fill_r[sel] != '0);
        dec.status = dec.hit ? ST_OK : ST_EMPTY;
      end
      default: begin
        sel = '0;
      end
    endcase
    sel_fill     = fill_r[sel];
    sel_fill_nxt = dec.is_pop ? sel_fill - FILL_W'(1) : sel_fill + FILL_W'(1);
    // Push writes at the old fill, pop reads one below it.
    dec.addr     = dec.is_pop ? {sel, sel_fill_nxt[DIDX_W-1:0]}
                              : {sel, sel_fill[DIDX_W-1:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NUM_STACKS; s++) begin
        fill_r[s] <= '0;
      end
    end else if (accept && dec.hit) begin
      fill_r[sel] <= sel_fill_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/bounded_stack_bank_unit.sv */
// Top level of the bounded stack bank: command port, capacity register,
// plate store RAM and result strobe. Depends on bsb_pkg, bsb_ctrl, bsb_ram.
`default_nettype none

// A bank of NUM_STACKS LIFO stacks sharing one plate store RAM. Issue a
// command with start while busy is low: push puts in_push_value on the
// lowest-numbered stack below capacity, pop takes the top of the
// highest-numbered non-empty stack, pop-at takes the top of stack
// in_stack_index. Every command returns exactly one result beat, shown
// for one cycle with out_valid high on the cycle after acceptance; the
// receiver cannot stall it, so capture it then. The fill counts and stack
// selection resolve in the accept cycle, and the RAM's registered read
// delivers the popped value in the next, during which busy is high.
// Status: 0 ok, 1 nothing to pop, 2 push rejected because all stacks are
// full. Write the capacity through cfg_* only while idle; values above
// MAX_DEPTH act as MAX_DEPTH and zero rejects every push. No clearing
// pass: the block is ready right after reset.
module bounded_stack_bank_unit
  import bsb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  // command channel
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [FUNC_W-1:0] in_func,
  input  wire logic [VAL_W-1:0]  in_push_value,
  input  wire logic [IDX_W-1:0]  in_stack_index,
  // result channel
  output logic                   out_valid,
  output logic [VAL_W-1:0]       out_pop_value,
  output logic [1:0]             out_status,
  // capacity register write channel
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CAP_W-1:0]  cfg_data
);

  logic [CAP_W-1:0]      cap_r;
  logic [FILL_W-1:0]     cap_eff;
  logic                  accept;
  bsb_dec_t              dec;
  logic                  pend_r;
  logic                  pop_hit_r;
  status_t               status_r;
  logic [DATA_WIDTH-1:0] ram_q;

  assign cfg_ready = 1'b1;
  assign busy      = pend_r;
  assign accept    = start && !busy;

  // Saturate capacity to the physical stack depth.
  assign cap_eff = (32'(cap_r) > MAX_DEPTH) ? FILL_W'(MAX_DEPTH) : FILL_W'(cap_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cap_r <= cfg_data;
    end
  end

  bsb_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .func        (in_func),
    .stack_index (in_stack_index),
    .cap_eff     (cap_eff),
    .dec         (dec)
  );

  // Push writes the store in the accept cycle; pop reads it and the data
  // lands in the result cycle. One command in flight, so no overlap.
  bsb_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (RAM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (accept && dec.hit && !dec.is_pop),
    .waddr (dec.addr),
    .wdata (DATA_WIDTH'(in_push_value)),
    .re    (accept && dec.hit && dec.is_pop),
    .raddr (dec.addr),
    .rdata (ram_q)
  );

  // Hold the result control for the strobe cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pop_hit_r <= dec.hit && dec.is_pop;
      status_r  <= dec.status;
    end
  end

  assign out_valid     = pend_r;
  assign out_pop_value = pop_hit_r ? VAL_W'(ram_q) : '0;
  assign out_status    = status_r;

`include "assert_macros.svh"

  `BSB_ASSERT(a_beat_follows, accept |=> out_valid, "accepted command gave no result beat")
  `BSB_ASSERT(a_single_beat, out_valid |=> !out_valid, "result beat repeated")
  `BSB_ASSERT(a_fail_zero, (out_valid && out_status != ST_OK) |-> (out_pop_value == '0),
              "failed command returned a nonzero value")
  `BSB_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid, "result beat right after reset")

endmodule

`default_nettype wire
